### hdl/fdtsbp_pkg.sv
package fdtsbp_pkg;

  localparam int unsigned MAX_DEPTH_DEFAULT = 15;
  localparam int unsigned DEPTH_W = 4;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TOK_END        = 32'h0000_0009;

  typedef enum logic [3:0] {
    K_BEGIN   = 4'd0,
    K_NAME    = 4'd1,
    K_ENDNODE = 4'd2,
    K_PROP    = 4'd3,
    K_LENGTH  = 4'd4,
    K_NAMEOFF = 4'd5,
    K_DATA    = 4'd6,
    K_NOP     = 4'd7,
    K_END     = 4'd8,
    K_IGNORED = 4'd9,
    K_UNKNOWN = 4'd10
  } kind_t;

endpackage

### hdl/fdt_structure_block_parser_core.sv
// A word's result is registered and appears on the master side in the cycle after the word is taken.
// Throughput: one word per cycle; the phase, depth and byte count update in a single
// register stage, and the output register accepts a new word whenever it is empty or
// its item is being taken in the same cycle.
// Reset (rst, synchronous): phase returns to token, depth and bytes left clear,
// and the output register is emptied.
module fdt_structure_block_parser_core #(
  parameter int unsigned MAX_DEPTH = fdtsbp_pkg::MAX_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // word[31:0]
  input  logic        s_axis_tuser,  // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // depth[3:0], prop_length[35:4], name_offset[67:36], bytes_valid[70:68],
  // depth_error[71]
  output logic [71:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,  // kind[3:0]
  output logic        m_axis_tlast   // last
);
  import fdtsbp_pkg::*;

  localparam int unsigned LimitInt = (MAX_DEPTH > 15) ? 15 : MAX_DEPTH;
  localparam logic [DEPTH_W-1:0] DepthLimit = DEPTH_W'(LimitInt);

  typedef enum logic [2:0] {
    PH_TOKEN = 3'd0,
    PH_NAME  = 3'd1,
    PH_LEN   = 3'd2,
    PH_OFF   = 3'd3,
    PH_DATA  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  phase_t             phase, phase_next, phase_cur;
  logic [DEPTH_W-1:0] nest_depth, nest_depth_next, depth_cur;
  logic [31:0]        bytes_left, bytes_left_next, left_cur;

  kind_t              kind_next;
  logic [31:0]        plen_next, noff_next;
  logic [2:0]         bv_next;
  logic               last_next, derr_next;

  logic               out_valid;
  kind_t              out_kind;
  logic [DEPTH_W-1:0] out_depth;
  logic [31:0]        out_plen, out_noff;
  logic [2:0]         out_bv;
  logic               out_last, out_derr;

  logic               accept;
  logic [31:0]        w;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign w             = s_axis_tdata;

  always_comb begin
    // A start request restarts the walk before this word is looked at.
    phase_cur = s_axis_tuser ? PH_TOKEN : phase;
    depth_cur = s_axis_tuser ? '0 : nest_depth;
    left_cur  = s_axis_tuser ? '0 : bytes_left;

    phase_next      = phase_cur;
    nest_depth_next = depth_cur;
    bytes_left_next = left_cur;
    kind_next       = K_IGNORED;
    plen_next       = '0;
    noff_next       = '0;
    bv_next         = '0;
    last_next       = 1'b0;
    derr_next       = 1'b0;

    unique case (phase_cur)
      PH_NAME: begin
        kind_next = K_NAME;
        if (w[31:24] == 8'h00) begin
          bv_next = 3'd0;
        end else if (w[23:16] == 8'h00) begin
          bv_next = 3'd1;
        end else if (w[15:8] == 8'h00) begin
          bv_next = 3'd2;
        end else if (w[7:0] == 8'h00) begin
          bv_next = 3'd3;
        end else begin
          bv_next = 3'd4;
        end
        if (bv_next != 3'd4) begin
          last_next  = 1'b1;
          phase_next = PH_TOKEN;
        end
      end
      PH_LEN: begin
        kind_next       = K_LENGTH;
        plen_next       = w;
        bytes_left_next = w;
        phase_next      = PH_OFF;
      end
      PH_OFF: begin
        kind_next = K_NAMEOFF;
        noff_next = w;
        if (left_cur == '0) begin
          last_next  = 1'b1;
          phase_next = PH_TOKEN;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        kind_next       = K_DATA;
        bv_next         = (left_cur > 32'd4) ? 3'd4 : left_cur[2:0];
        bytes_left_next = left_cur - {29'd0, bv_next};
        if (bytes_left_next == '0) begin
          last_next  = 1'b1;
          phase_next = PH_TOKEN;
        end
      end
      PH_DONE: begin
        kind_next = K_IGNORED;
      end
      default: begin
        // Token phase; any undefined phase code is read as a token too.
        phase_next = PH_TOKEN;
        if (w == TOK_BEGIN_NODE) begin
          kind_next  = K_BEGIN;
          phase_next = PH_NAME;
          if (depth_cur >= DepthLimit) begin
            nest_depth_next = DepthLimit;
            derr_next       = 1'b1;
          end else begin
            nest_depth_next = depth_cur + 1'b1;
          end
        end else if (w == TOK_END_NODE) begin
          kind_next = K_ENDNODE;
          if (depth_cur == '0) begin
            derr_next = 1'b1;
          end else begin
            nest_depth_next = depth_cur - 1'b1;
          end
        end else if (w == TOK_PROP) begin
          kind_next  = K_PROP;
          phase_next = PH_LEN;
        end else if (w == TOK_NOP) begin
          kind_next = K_NOP;
        end else if (w == TOK_END) begin
          kind_next  = K_END;
          phase_next = PH_DONE;
        end else begin
          kind_next = K_UNKNOWN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TOKEN;
      nest_depth <= '0;
      bytes_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        nest_depth <= nest_depth_next;
        bytes_left <= bytes_left_next;
        out_valid  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind  <= kind_next;
      out_depth <= nest_depth_next;
      out_plen  <= plen_next;
      out_noff  <= noff_next;
      out_bv    <= bv_next;
      out_last  <= last_next;
      out_derr  <= derr_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {out_derr, out_bv, out_noff, out_plen, out_depth};

  a_depth_in_range: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DepthLimit)
    else $error("nesting depth beyond its limit");

  a_error_only_on_node_tokens: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_derr) |-> (out_kind == K_BEGIN || out_kind == K_ENDNODE))
    else $error("depth error on a word that is not a node token");

  a_last_kinds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |->
      (out_kind == K_NAME || out_kind == K_NAMEOFF || out_kind == K_DATA))
    else $error("last mark on a word that ends neither name nor data");

  a_bytes_valid_kinds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bv != 3'd0) |-> (out_kind == K_NAME || out_kind == K_DATA))
    else $error("bytes valid set on a word without name or data bytes");

  a_done_ignores: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DONE && !s_axis_tuser) |=> (out_kind == K_IGNORED))
    else $error("word after the end token was not ignored");

endmodule
